[rtl/core/fdss_pkg.sv]
// Shared types, constants and lookup tables for the four-digit seven-segment scan block.
// No dependencies. Every other file in rtl/core imports this package.
`default_nettype none

package fdss_pkg;

    // Number of scanned digit positions. The supported range is 1 to 8.
    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    localparam int SWITCH_W  = 16;
    localparam int BUTTON_W  = 2;
    localparam int REMOTE_W  = 8;
    localparam int ANODE_W   = 4;
    localparam int SEGMENT_W = 8;
    localparam int DIGIT_W   = 4;

    // Button bits.
    localparam int BTN_LOCAL  = 0;
    localparam int BTN_REMOTE = 1;

    // A digit is taken from the fractional part of value / 10^(p+1), which is
    // approximated by value * ceil(2^FRAC_SHIFT / 10^(p+1)) in fixed point.
    localparam int FRAC_SHIFT = 33;
    localparam int RECIP_W    = 30;
    localparam int RECIP_IDX_W = 3;
    localparam int PRODUCT_W  = SWITCH_W + RECIP_W;
    localparam int TIMES10_W  = FRAC_SHIFT + DIGIT_W;

    localparam logic [RECIP_W-1:0] RECIP_TABLE [2**RECIP_IDX_W] = '{
        30'd858993460,
        30'd85899346,
        30'd8589935,
        30'd858994,
        30'd85900,
        30'd8590,
        30'd859,
        30'd86
    };

    // Active-low hex font.
    localparam logic [SEGMENT_W-1:0] SEG_FONT [2**DIGIT_W] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
    };

    // What the decoder drives for one digit position.
    typedef struct packed {
        logic [ANODE_W-1:0]   anode;
        logic [SEGMENT_W-1:0] segment;
    } fdss_drive_t;

endpackage

`default_nettype wire

[rtl/core/fdss_digit_decode.sv]
// Digit extraction and font lookup for one scan position.
// Depends on fdss_pkg for the reciprocal table, the font and the drive struct.
`default_nettype none

module fdss_digit_decode
    import fdss_pkg::*;
(
    input  wire logic [SWITCH_W-1:0] shown,
    input  wire logic [POS_W-1:0]    pos,
    output fdss_drive_t              drive
);

    logic [RECIP_W-1:0]    recip;
    logic [PRODUCT_W-1:0]  product;
    logic [TIMES10_W-1:0]  frac_ext;
    logic [TIMES10_W-1:0]  times10;
    logic [DIGIT_W-1:0]    digit;

    // The integer part of the product is the value modulo nothing we need; the
    // fractional part scaled by ten gives the wanted decimal digit directly.
    assign recip    = RECIP_TABLE[RECIP_IDX_W'(pos)];
    assign product  = PRODUCT_W'(shown) * PRODUCT_W'(recip);
    assign frac_ext = TIMES10_W'(product[FRAC_SHIFT-1:0]);
    assign times10  = (frac_ext << 3) + (frac_ext << 1);
    assign digit    = times10[TIMES10_W-1:FRAC_SHIFT];

    always_comb
    begin
        drive.segment = SEG_FONT[digit];
        if (int'(pos) < ANODE_W)
        begin
            drive.anode = ~(ANODE_W'(1) << pos);
        end
        else
        begin
            drive.anode = '1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/four_digit_seven_segment_scan.sv]
// Top level of the four-digit multiplexed seven-segment scan controller.
// Depends on fdss_pkg and fdss_digit_decode.
//
// Usage:
//   Each input transaction (in_valid, in_stall, switches, buttons, remote_byte) is one
//   scan tick. Button bit 0 selects the local view of the switches; otherwise button
//   bit 1 latches remote_byte and selects the remote view. No button keeps the view.
//   Each tick yields one output transaction (out_valid, out_stall): the active-low
//   anode for the current digit position, the font pattern of that decimal digit of
//   the shown value, and the switch value echoed on led_lines. The position then
//   advances modulo DIGIT_COUNT.
//   Each transaction is held first in the input register and then in the result
//   register, from which it is presented.
//   Throughput: one transaction per cycle while out_stall is low; the digit multiply
//   and font lookup sit in a single stage between the two registers.
//   Reset: asynchronous, active low. The view returns to local, the held byte and the
//   digit position clear, and both pipeline registers empty.
//   Stall: a stalled result holds its value. An empty input register still takes one
//   more transaction; with both registers full, in_stall follows out_stall in the same cycle.
`default_nettype none

module four_digit_seven_segment_scan
    import fdss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [SWITCH_W-1:0]  switches,
    input  wire logic [BUTTON_W-1:0]  buttons,
    input  wire logic [REMOTE_W-1:0]  remote_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [ANODE_W-1:0]        anode_lines,
    output logic [SEGMENT_W-1:0]      segment_lines,
    output logic [SWITCH_W-1:0]       led_lines
);

    logic                 show_remote_reg, show_remote_next;
    logic [REMOTE_W-1:0]  held_remote_reg, held_remote_next;
    logic [POS_W-1:0]     position_reg, position_next;

    logic                 s1_valid_reg;
    logic [SWITCH_W-1:0]  s1_shown_reg, s1_shown_next;
    logic [POS_W-1:0]     s1_pos_reg;
    logic [SWITCH_W-1:0]  s1_switches_reg;

    logic                 out_valid_reg;
    fdss_drive_t          out_drive_reg;
    logic [SWITCH_W-1:0]  out_leds_reg;

    fdss_drive_t          drive;
    logic                 accept;
    logic                 out_free;
    logic                 s1_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || out_free;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    // View selection: the local button wins over the remote button.
    always_comb
    begin
        show_remote_next = show_remote_reg;
        held_remote_next = held_remote_reg;
        priority if (buttons[BTN_LOCAL])
        begin
            show_remote_next = 1'b0;
        end
        else if (buttons[BTN_REMOTE])
        begin
            show_remote_next = 1'b1;
            held_remote_next = remote_byte;
        end

        s1_shown_next = show_remote_next ? SWITCH_W'(held_remote_next) : switches;

        if (int'(position_reg) == DIGIT_COUNT - 1)
        begin
            position_next = '0;
        end
        else
        begin
            position_next = position_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_remote_reg <= 1'b0;
            held_remote_reg <= '0;
            position_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                show_remote_reg <= show_remote_next;
                held_remote_reg <= held_remote_next;
                position_reg    <= position_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_shown_reg    <= s1_shown_next;
            s1_pos_reg      <= position_reg;
            s1_switches_reg <= switches;
        end
        if (out_free && s1_valid_reg)
        begin
            out_drive_reg <= drive;
            out_leds_reg  <= s1_switches_reg;
        end
    end

    fdss_digit_decode u_decode (
        .shown (s1_shown_reg),
        .pos   (s1_pos_reg),
        .drive (drive)
    );

    assign out_valid     = out_valid_reg;
    assign anode_lines   = out_drive_reg.anode;
    assign segment_lines = out_drive_reg.segment;
    assign led_lines     = out_leds_reg;

endmodule

`default_nettype wire

[rtl/core/fdss_checker.sv]
// Port-level checker for four_digit_seven_segment_scan, attached by the bind below.
// Depends on fdss_pkg for widths and the digit count.
`default_nettype none

module fdss_checker
    import fdss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_stall,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [ANODE_W-1:0]   anode_lines,
    input  wire logic [SEGMENT_W-1:0] segment_lines,
    input  wire logic [SWITCH_W-1:0]  led_lines
);

    // A held result must not change while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(anode_lines)
            && $stable(segment_lines) && $stable(led_lines))
    else $error("stalled output transaction changed");

    // The input side only backs up when a result is waiting on a stalled receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

    // With at most four positions, exactly one anode is pulled low per result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (DIGIT_COUNT <= ANODE_W) |-> $countones(~anode_lines) == 1)
    else $error("anode pattern does not select exactly one digit");

    // Decimal digits only reach font entries with the decimal point segment off.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> segment_lines[SEGMENT_W-1])
    else $error("segment pattern outside the decimal font");

    // Reset empties the result register.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result valid during reset");

endmodule

bind four_digit_seven_segment_scan fdss_checker u_fdss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .anode_lines   (anode_lines),
    .segment_lines (segment_lines),
    .led_lines     (led_lines)
);

`default_nettype wire
